@@ src/rbnh_pkg.sv @@
`timescale 1ns / 1ps
package rbnh_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int T_W        = 52;
    localparam int DS_NUM_W   = 64;
    localparam int DS_DEN_W   = 32;
    localparam int DS_RES_W   = 48;
    localparam int DS_REM_W   = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_DIR_X     = 3'd2,
        REG_DIR_Y     = 3'd3,
        REG_LENGTH    = 3'd4,
        REG_LAYER_SEL = 3'd5,
        REG_IGNORED   = 3'd6,
        REG_TRIGGERS  = 3'd7
    } t_cfg_reg;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic                start;
        logic                is_sqrt;
        logic [DS_NUM_W-1:0] num;
        logic [DS_DEN_W-1:0] den;
    } t_ds_req;

    typedef struct packed {
        logic                done;
        logic [DS_RES_W-1:0] res;
    } t_ds_rsp;

endpackage

@@ src/rbnh_box_if.sv @@
`timescale 1ns / 1ps
interface rbnh_box_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic [31:0]       box_entity;
    logic [4:0]        box_layer;
    logic              box_is_trigger;
    logic              last_box;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y, box_entity,
               box_layer, box_is_trigger, last_box,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y, box_entity,
               box_layer, box_is_trigger, last_box,
        output ready
    );
endinterface

@@ src/rbnh_hit_if.sv @@
`timescale 1ns / 1ps
interface rbnh_hit_if;
    logic              valid;
    logic              ready;
    logic              hit_found;
    logic [30:0]       hit_distance;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [1:0] hit_normal_x;
    logic signed [1:0] hit_normal_y;
    logic [31:0]       hit_entity;

    modport source (
        output valid, hit_found, hit_distance, hit_point_x, hit_point_y,
               hit_normal_x, hit_normal_y, hit_entity,
        input  ready
    );
    modport sink (
        input  valid, hit_found, hit_distance, hit_point_x, hit_point_y,
               hit_normal_x, hit_normal_y, hit_entity,
        output ready
    );
endinterface

@@ src/rbnh_mul.sv @@
`timescale 1ns / 1ps
module rbnh_mul import rbnh_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [PROD_W-1:0]  o_prod
);

    logic [PROD_W-1:0] r_prod;

    // register the unsigned product
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ src/rbnh_divsqrt.sv @@
`timescale 1ns / 1ps
module rbnh_divsqrt import rbnh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ds_req i_req,
    output t_ds_rsp o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic                r_sqrt;
    logic [DS_NUM_W-1:0] r_num;
    logic [DS_REM_W-1:0] r_rem;
    logic [DS_RES_W-1:0] r_res;
    logic [DS_DEN_W-1:0] r_den;
    logic [5:0]          r_cnt;

    logic [DS_REM_W-1:0] w_rem_sh;
    logic [DS_REM_W-1:0] w_trial;
    logic                w_take;

    // one restoring step: two radicand bits for the root, one dividend bit for the quotient
    always_comb begin
        if (r_sqrt) begin
            w_rem_sh = {r_rem[DS_REM_W-3:0], r_num[DS_NUM_W-1 -: 2]};
            w_trial  = {2'b00, r_res[31:0], 2'b01};
        end else begin
            w_rem_sh = {r_rem[DS_REM_W-2:0], r_num[DS_NUM_W-1]};
            w_trial  = {4'b0000, r_den};
        end
        w_take = (w_rem_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= i_req.is_sqrt ? 6'd31 : 6'd47;
            end else if (r_busy) begin
                r_rem <= w_take ? (w_rem_sh - w_trial) : w_rem_sh;
                r_res <= {r_res[DS_RES_W-2:0], w_take};
                r_num <= r_sqrt ? {r_num[DS_NUM_W-3:0], 2'b00} : {r_num[DS_NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

@@ src/ray_box_nearest_hit.sv @@
`timescale 1ns / 1ps
// Nearest hit of a 2D ray against a stream of boxes, Q16.16 fixed point. The block takes
// one box at a time and is not ready while it works on it. A box that the filters skip is
// not tested. A tested box picks each axis in turn; for an axis with a nonzero direction
// it makes 4 passes of the shared 33x17 multiplier, forms both slab parameters and
// narrows the interval; if it stays open it compares the entry distance with the kept
// hit. The last box of a query forms the hit point through the same multiplier (not on
// a miss) and loads the output register, waiting while an earlier result is still there.
// The first box after reset or after a direction write also normalizes the direction:
// it squares the length through the multiplier, then runs a 32-step square root and,
// unless the length is zero, four 48-step divisions on the shared serial divide unit.
// A result waits in the output register while the next box is taken.
module ray_box_nearest_hit import rbnh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rbnh_box_if.sink              i_box,
    rbnh_hit_if.source            o_hit
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQRT, S_DIVX, S_DIVY,
        S_RCPX, S_RCPY, S_FILT, S_AXIS, S_T1L, S_T1H, S_T2L, S_T2H, S_T2,
        S_UPD, S_KEEP, S_BEND, S_PX, S_PY, S_PYC, S_EMIT
    } t_state;

    // configuration
    logic signed [31:0] r_start_x, r_start_y, r_dir_x, r_dir_y;
    logic [30:0]        r_len;
    logic [31:0]        r_layer_sel, r_ignored;
    logic               r_acc_trig;

    // latched box
    logic signed [31:0] r_bx_lo_x, r_bx_lo_y, r_bx_hi_x, r_bx_hi_y;
    logic [31:0]        r_bx_ent;
    logic [4:0]         r_bx_layer;
    logic               r_bx_trig, r_bx_last;

    // sequencer state
    t_state             r_state;
    logic               r_qready;
    logic [16:0]        r_ux_mag, r_uy_mag;
    logic               r_ux_neg, r_uy_neg;
    logic [32:0]        r_rx_mag, r_ry_mag;
    logic [63:0]        r_acc;
    logic [32:0]        r_tacc;
    logic signed [T_W-1:0] r_t1, r_t2, r_tmin, r_tmax;
    logic               r_axis;
    logic signed [1:0]  r_nx, r_ny;
    logic               r_best_valid;
    logic [30:0]        r_best_dist;
    logic signed [1:0]  r_best_nx, r_best_ny;
    logic [31:0]        r_best_ent;
    logic signed [31:0] r_px, r_py;
    logic               r_ds_start, r_ds_sqrt;
    logic [DS_NUM_W-1:0] r_ds_num;
    logic [DS_DEN_W-1:0] r_ds_den;

    // output register
    logic               r_ov, r_o_found;
    logic [30:0]        r_o_dist;
    logic signed [31:0] r_o_px, r_o_py;
    logic signed [1:0]  r_o_nx, r_o_ny;
    logic [31:0]        r_o_ent;

    t_ds_req            w_ds_req;
    t_ds_rsp            w_ds_rsp;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;

    logic [31:0]        w_mx, w_my;
    logic signed [31:0] w_s, w_lo, w_hi;
    logic signed [32:0] w_dlo, w_dhi;
    logic [32:0]        w_dlo_mag, w_dhi_mag;
    logic [16:0]        w_umag;
    logic               w_uneg;
    logic [32:0]        w_rmag;
    logic [50:0]        w_tsum;
    logic signed [T_W-1:0] w_tval;
    logic               w_tneg;
    logic signed [T_W-1:0] w_tlo, w_thi, w_nmin, w_nmax;
    logic               w_tmin_upd;
    logic [63:0]        w_sq_sum;
    logic               w_pass;
    logic [30:0]        w_cmp;
    logic signed [31:0] w_pt_s;
    logic               w_pt_neg;
    logic [33:0]        w_pt_mag;
    logic signed [33:0] w_pt_v;
    logic signed [31:0] w_pt_sat;

    assign w_ds_req = '{start: r_ds_start, is_sqrt: r_ds_sqrt, num: r_ds_num, den: r_ds_den};

    rbnh_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    rbnh_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ds_req),
        .o_rsp   (w_ds_rsp)
    );

    // direction magnitudes and the current axis of the slab test
    always_comb begin
        w_mx      = r_dir_x[31] ? (~r_dir_x + 32'd1) : r_dir_x;
        w_my      = r_dir_y[31] ? (~r_dir_y + 32'd1) : r_dir_y;
        w_s       = r_axis ? r_start_y : r_start_x;
        w_lo      = r_axis ? r_bx_lo_y : r_bx_lo_x;
        w_hi      = r_axis ? r_bx_hi_y : r_bx_hi_x;
        w_umag    = r_axis ? r_uy_mag : r_ux_mag;
        w_uneg    = r_axis ? r_uy_neg : r_ux_neg;
        w_rmag    = r_axis ? r_ry_mag : r_rx_mag;
        w_dlo     = {w_lo[31], w_lo} - {w_s[31], w_s};
        w_dhi     = {w_hi[31], w_hi} - {w_s[31], w_s};
        w_dlo_mag = w_dlo[32] ? (~w_dlo + 33'd1) : w_dlo;
        w_dhi_mag = w_dhi[32] ? (~w_dhi + 33'd1) : w_dhi;
    end

    // slab parameter: high partial plus low partial shifted down, then signed
    always_comb begin
        w_tsum = 51'(r_tacc) + 51'(w_prod);
        w_tneg = ((r_state == S_T2L) ? w_dlo[32] : w_dhi[32]) ^ w_uneg;
        w_tval = w_tneg ? -$signed({1'b0, w_tsum}) : $signed({1'b0, w_tsum});
    end

    // interval update of the current axis
    always_comb begin
        w_tlo      = (r_t1 > r_t2) ? r_t2 : r_t1;
        w_thi      = (r_t1 > r_t2) ? r_t1 : r_t2;
        w_tmin_upd = (w_tlo > r_tmin);
        w_nmin     = w_tmin_upd ? w_tlo : r_tmin;
        w_nmax     = (w_thi < r_tmax) ? w_thi : r_tmax;
    end

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_SQ0: begin w_mul_a = {1'b0, w_mx}; w_mul_b = {1'b0, w_mx[15:0]}; end
            S_SQ1: begin w_mul_a = {1'b0, w_mx}; w_mul_b = {1'b0, w_mx[31:16]}; end
            S_SQ2: begin w_mul_a = {1'b0, w_my}; w_mul_b = {1'b0, w_my[15:0]}; end
            S_SQ3: begin w_mul_a = {1'b0, w_my}; w_mul_b = {1'b0, w_my[31:16]}; end
            S_T1L: begin w_mul_a = w_dlo_mag; w_mul_b = {1'b0, w_rmag[15:0]}; end
            S_T1H: begin w_mul_a = w_dlo_mag; w_mul_b = w_rmag[32:16]; end
            S_T2L: begin w_mul_a = w_dhi_mag; w_mul_b = {1'b0, w_rmag[15:0]}; end
            S_T2H: begin w_mul_a = w_dhi_mag; w_mul_b = w_rmag[32:16]; end
            S_PX:  begin w_mul_a = {2'b00, r_best_dist}; w_mul_b = r_ux_mag; end
            S_PY:  begin w_mul_a = {2'b00, r_best_dist}; w_mul_b = r_uy_mag; end
            default: begin w_mul_a = '0; w_mul_b = '0; end
        endcase
    end

    // filters, best compare, hit point with saturation
    always_comb begin
        w_sq_sum = r_acc + 64'({w_prod, 16'h0000});
        w_pass   = (r_bx_ent != r_ignored) && !(r_bx_trig && !r_acc_trig) &&
                   r_layer_sel[r_bx_layer];
        w_cmp    = r_best_valid ? r_best_dist : r_len;
        w_pt_s   = (r_state == S_PY) ? r_start_x : r_start_y;
        w_pt_neg = (r_state == S_PY) ? r_ux_neg : r_uy_neg;
        w_pt_mag = w_prod[PROD_W-1:16];
        w_pt_v   = {{2{w_pt_s[31]}}, w_pt_s} +
                   (w_pt_neg ? -$signed(w_pt_mag) : $signed(w_pt_mag));
        if (!w_pt_v[33] && (w_pt_v[32:31] != 2'b00)) begin
            w_pt_sat = 32'sh7FFF_FFFF;
        end else if (w_pt_v[33] && (w_pt_v[32:31] != 2'b11)) begin
            w_pt_sat = 32'sh8000_0000;
        end else begin
            w_pt_sat = w_pt_v[31:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_dir_x     <= 32'sh0001_0000;
            r_dir_y     <= '0;
            r_len       <= '0;
            r_layer_sel <= '1;
            r_ignored   <= '0;
            r_acc_trig  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_START_X:   r_start_x   <= i_cfg_data;
                REG_START_Y:   r_start_y   <= i_cfg_data;
                REG_DIR_X:     r_dir_x     <= i_cfg_data;
                REG_DIR_Y:     r_dir_y     <= i_cfg_data;
                REG_LENGTH:    r_len       <= i_cfg_data[30:0];
                REG_LAYER_SEL: r_layer_sel <= i_cfg_data;
                REG_IGNORED:   r_ignored   <= i_cfg_data;
                REG_TRIGGERS:  r_acc_trig  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_qready     <= 1'b0;
            r_best_valid <= 1'b0;
            r_best_dist  <= '0;
            r_best_nx    <= '0;
            r_best_ny    <= '0;
            r_best_ent   <= '0;
            r_ov         <= 1'b0;
            r_ds_start   <= 1'b0;
        end else begin
            // pulse the divide unit at each hand-off of the normalization chain
            r_ds_start <= (r_state == S_SQ4) ||
                          (w_ds_rsp.done &&
                           (((r_state == S_SQRT) && (w_ds_rsp.res[31:0] != 32'd0)) ||
                            (r_state == S_DIVX) || (r_state == S_DIVY) ||
                            (r_state == S_RCPX)));
            if (o_hit.valid && o_hit.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && ((i_cfg_idx == REG_DIR_X) || (i_cfg_idx == REG_DIR_Y))) begin
                r_qready <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_box.valid) begin
                        r_bx_lo_x  <= i_box.box_min_x;
                        r_bx_lo_y  <= i_box.box_min_y;
                        r_bx_hi_x  <= i_box.box_max_x;
                        r_bx_hi_y  <= i_box.box_max_y;
                        r_bx_ent   <= i_box.box_entity;
                        r_bx_layer <= i_box.box_layer;
                        r_bx_trig  <= i_box.box_is_trigger;
                        r_bx_last  <= i_box.last_box;
                        r_state    <= r_qready ? S_FILT : S_SQ0;
                    end
                end
                S_SQ0: r_state <= S_SQ1;
                S_SQ1: begin
                    r_acc   <= 64'(w_prod);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_acc   <= w_sq_sum;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    r_acc   <= r_acc + 64'(w_prod);
                    r_state <= S_SQ4;
                end
                S_SQ4: begin
                    r_ds_sqrt  <= 1'b1;
                    r_ds_num   <= w_sq_sum;
                    r_state    <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_ds_rsp.done) begin
                        r_ds_den <= w_ds_rsp.res[31:0];
                        if (w_ds_rsp.res[31:0] == 32'd0) begin
                            r_ux_mag <= '0;
                            r_uy_mag <= '0;
                            r_ux_neg <= 1'b0;
                            r_uy_neg <= 1'b0;
                            r_rx_mag <= '0;
                            r_ry_mag <= '0;
                            r_qready <= 1'b1;
                            r_state  <= S_FILT;
                        end else begin
                            r_ds_sqrt  <= 1'b0;
                            r_ds_num   <= {w_mx, 32'h0};
                            r_state    <= S_DIVX;
                        end
                    end
                end
                S_DIVX: begin
                    if (w_ds_rsp.done) begin
                        r_ux_mag   <= w_ds_rsp.res[16:0];
                        r_ux_neg   <= r_dir_x[31];
                        r_ds_num   <= {w_my, 32'h0};
                        r_state    <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_ds_rsp.done) begin
                        r_uy_mag   <= w_ds_rsp.res[16:0];
                        r_uy_neg   <= r_dir_y[31];
                        r_ds_num   <= {16'h0001, 48'h0};
                        r_ds_den   <= {15'h0, r_ux_mag};
                        r_state    <= S_RCPX;
                    end
                end
                S_RCPX: begin
                    if (w_ds_rsp.done) begin
                        r_rx_mag   <= (r_ux_mag == '0) ? '0 : w_ds_rsp.res[32:0];
                        r_ds_num   <= {16'h0001, 48'h0};
                        r_ds_den   <= {15'h0, r_uy_mag};
                        r_state    <= S_RCPY;
                    end
                end
                S_RCPY: begin
                    if (w_ds_rsp.done) begin
                        r_ry_mag <= (r_uy_mag == '0) ? '0 : w_ds_rsp.res[32:0];
                        r_qready <= 1'b1;
                        r_state  <= S_FILT;
                    end
                end
                S_FILT: begin
                    r_tmin  <= '0;
                    r_tmax  <= T_W'(r_len);
                    r_nx    <= '0;
                    r_ny    <= '0;
                    r_axis  <= 1'b0;
                    r_state <= w_pass ? S_AXIS : S_BEND;
                end
                S_AXIS: begin
                    if (w_umag != '0) begin
                        r_state <= S_T1L;
                    end else if ((w_s < w_lo) || (w_s > w_hi)) begin
                        r_state <= S_BEND;
                    end else if (!r_axis) begin
                        r_axis <= 1'b1;
                    end else begin
                        r_state <= S_KEEP;
                    end
                end
                S_T1L: r_state <= S_T1H;
                S_T1H: begin
                    r_tacc  <= w_prod[PROD_W-2:16];
                    r_state <= S_T2L;
                end
                S_T2L: begin
                    r_t1    <= w_tval;
                    r_state <= S_T2H;
                end
                S_T2H: begin
                    r_tacc  <= w_prod[PROD_W-2:16];
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_t2    <= w_tval;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_tmin <= w_nmin;
                    r_tmax <= w_nmax;
                    if (w_tmin_upd) begin
                        if (!r_axis) begin
                            r_nx <= w_uneg ? 2'sd1 : -2'sd1;
                        end else begin
                            r_nx <= '0;
                            r_ny <= w_uneg ? 2'sd1 : -2'sd1;
                        end
                    end
                    if (w_nmin > w_nmax) begin
                        r_state <= S_BEND;
                    end else if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_AXIS;
                    end else begin
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: begin
                    if (r_tmin < $signed(T_W'(w_cmp))) begin
                        r_best_valid <= 1'b1;
                        r_best_dist  <= r_tmin[30:0];
                        r_best_nx    <= r_nx;
                        r_best_ny    <= r_ny;
                        r_best_ent   <= r_bx_ent;
                    end
                    r_state <= S_BEND;
                end
                S_BEND: begin
                    if (!r_bx_last) begin
                        r_state <= S_IDLE;
                    end else if (r_best_valid) begin
                        r_state <= S_PX;
                    end else begin
                        r_px    <= '0;
                        r_py    <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_PX: r_state <= S_PY;
                S_PY: begin
                    r_px    <= w_pt_sat;
                    r_state <= S_PYC;
                end
                S_PYC: begin
                    r_py    <= w_pt_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // wait for the output register, then load it and clear the kept hit
                    if (!r_ov || o_hit.ready) begin
                        r_ov         <= 1'b1;
                        r_o_found    <= r_best_valid;
                        r_o_dist     <= r_best_valid ? r_best_dist : r_len;
                        r_o_px       <= r_px;
                        r_o_py       <= r_py;
                        r_o_nx       <= r_best_valid ? r_best_nx : 2'sd0;
                        r_o_ny       <= r_best_valid ? r_best_ny : 2'sd0;
                        r_o_ent      <= r_best_valid ? r_best_ent : 32'd0;
                        r_best_valid <= 1'b0;
                        r_best_dist  <= '0;
                        r_best_nx    <= '0;
                        r_best_ny    <= '0;
                        r_best_ent   <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_box.ready        = (r_state == S_IDLE);
    assign o_hit.valid        = r_ov;
    assign o_hit.hit_found    = r_o_found;
    assign o_hit.hit_distance = r_o_dist;
    assign o_hit.hit_point_x  = r_o_px;
    assign o_hit.hit_point_y  = r_o_py;
    assign o_hit.hit_normal_x = r_o_nx;
    assign o_hit.hit_normal_y = r_o_ny;
    assign o_hit.hit_entity   = r_o_ent;

    // divide unit answers only while the sequencer waits for it
    a_ds_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_rsp.done |-> (r_state == S_SQRT) || (r_state == S_DIVX) ||
                          (r_state == S_DIVY) || (r_state == S_RCPX) || (r_state == S_RCPY))
        else $error("divide unit done outside a wait state");

    // a box taken with a normalized direction goes straight to filtering
    a_box_to_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready && r_qready && !i_cfg_we) |=> (r_state == S_FILT))
        else $error("box did not enter filtering");

    // loading a result clears the kept hit
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !r_ov) |=> (r_ov && !r_best_valid))
        else $error("result not loaded or kept hit not cleared");

    // a miss carries no entity, point or normal
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_found) |-> ((r_o_ent == 32'd0) && (r_o_px == 32'sd0) &&
                                  (r_o_py == 32'sd0) && (r_o_nx == 2'sd0) && (r_o_ny == 2'sd0)))
        else $error("miss result with nonzero fields");

endmodule
